/* hw/rtl/pcrf_pkg.sv */
// Package of the power companion register file: bus operation codes,
// register addresses, and the reset, mask and clamp rules of the control bytes.
// No dependencies; pcrf_ctrl_mem and the top level refer to it by scoped names.
package pcrf_pkg;

    localparam int NumCtrl = 30;
    localparam int SlotW   = $clog2(NumCtrl);

    typedef logic [SlotW-1:0] slot_t;

    // Bus operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_PIN   = 2'd3;

    localparam logic [1:0] PIN_BUTTON = 2'd3;

    // Register addresses outside the control byte store
    localparam logic [7:0] ADDR_REVISION   = 8'h01;
    localparam logic [7:0] ADDR_DEVICE_OFF = 8'h14;
    localparam logic [7:0] ADDR_MASK_LO    = 8'h17;
    localparam logic [7:0] ADDR_MASK_HI    = 8'h18;
    localparam logic [7:0] ADDR_STATUS_LO  = 8'h19;
    localparam logic [7:0] ADDR_STATUS_HI  = 8'h1a;
    localparam logic [7:0] ADDR_ACK_LO     = 8'h1b;
    localparam logic [7:0] ADDR_ACK_HI     = 8'h1c;
    localparam logic [7:0] ADDR_GPIO_DIR   = 8'h1d;
    localparam logic [7:0] ADDR_GPIO_IN    = 8'h1e;
    localparam logic [7:0] ADDR_GPIO_OUT   = 8'h1f;
    localparam logic [7:0] ADDR_RTC_COMP_HI = 8'h30;
    localparam logic [7:0] ADDR_RTC_COMP_LO = 8'h31;

    localparam logic [7:0]  REVISION_ID      = 8'h22;
    localparam logic [4:0]  CLAMP_MAX        = 5'h12;
    localparam logic [15:0] INT_MASK_RESET   = 16'h0fff;
    localparam logic [7:0]  GPIO_DIR_RESET   = 8'h07;
    localparam logic [7:0]  GPIO_DIR_MASK    = 8'h67;
    localparam logic [7:0]  BBSMS_FIXED      = 8'h0d;
    localparam logic [7:0]  OSC_READ_SET     = 8'h80;
    localparam int          BUTTON_STATUS_BIT = 11;

    // Control byte slots with special write or read rules
    localparam slot_t SLOT_CLAMP_MIXED = 5'd0;
    localparam slot_t SLOT_CLAMP_A     = 5'd2;
    localparam slot_t SLOT_CLAMP_B     = 5'd3;
    localparam slot_t SLOT_OSC         = 5'd18;
    localparam slot_t SLOT_BBSMS       = 5'd20;

    typedef struct packed {
        logic  hit;
        slot_t slot;
    } slot_map_t;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic       clear;
        slot_t      slot;
        logic [7:0] wr_data;
    } mem_cmd_t;

    function automatic slot_map_t slot_of(logic [7:0] a);
        slot_map_t m;
        m.hit  = 1'b1;
        m.slot = '0;
        if (a >= 8'h02 && a <= 8'h13)
        begin
            m.slot = slot_t'(a - 8'h02);
        end
        else if (a == 8'h15)
        begin
            m.slot = 5'd18;
        end
        else if (a == 8'h16)
        begin
            m.slot = 5'd19;
        end
        else if (a == 8'h20)
        begin
            m.slot = 5'd20;
        end
        else if (a == 8'h21)
        begin
            m.slot = 5'd21;
        end
        else if (a >= 8'h32 && a <= 8'h38)
        begin
            m.slot = slot_t'(a - 8'h32) + 5'd22;
        end
        else if (a == 8'h3a)
        begin
            m.slot = 5'd29;
        end
        else
        begin
            m.hit = 1'b0;
        end
        return m;
    endfunction

    function automatic logic [7:0] reset_value(slot_t s);
        logic [7:0] v;
        unique case (s)
            5'd0:    v = 8'h0c;
            5'd1:    v = 8'h05;
            5'd2:    v = 8'h02;
            5'd3:    v = 8'h0c;
            5'd4:    v = 8'h03;
            5'd5:    v = 8'h33;
            5'd6:    v = 8'h03;
            5'd8:    v = 8'h95;
            5'd9:    v = 8'h7e;
            5'd12:   v = 8'h03;
            5'd18:   v = 8'h01;
            5'd19:   v = 8'h09;
            5'd26:   v = 8'h03;
            5'd27:   v = 8'hc0;
            5'd29:   v = 8'h05;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] write_mask(slot_t s);
        logic [7:0] v;
        unique case (s)
            5'd2, 5'd3, 5'd21, 5'd23, 5'd25: v = 8'h1f;
            5'd4, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15: v = 8'h03;
            5'd5, 5'd29:                     v = 8'h3f;
            5'd6, 5'd7, 5'd18:               v = 8'h07;
            5'd9, 5'd19, 5'd26:              v = 8'h7f;
            5'd28:                           v = 8'h0f;
            default:                         v = 8'hff;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] clamp12(logic [7:0] v);
        logic [4:0] t;
        t = v[4:0];
        return (t > CLAMP_MAX) ? {3'b000, CLAMP_MAX} : {3'b000, t};
    endfunction

    function automatic logic [7:0] write_value(slot_t s, logic [7:0] v);
        logic [7:0] r;
        if (s == SLOT_CLAMP_MIXED)
        begin
            r = (v & 8'h0e) | clamp12(v);
        end
        else if (s == SLOT_CLAMP_A || s == SLOT_CLAMP_B)
        begin
            r = clamp12(v);
        end
        else if (s == SLOT_BBSMS)
        begin
            r = BBSMS_FIXED;
        end
        else
        begin
            r = v & write_mask(s);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/pcrf_req_if.sv */
// Request channel of the power companion register file: one bus event per item.
// Depends on nothing but the valid/ready handshake it carries.
interface pcrf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data;
    logic [1:0] pin;
    logic       level;

    modport source (output valid, output op, output data, output pin, output level,
                    input ready);
    modport sink   (input valid, input op, input data, input pin, input level,
                    output ready);
endinterface

/* hw/rtl/pcrf_rsp_if.sv */
// Response channel of the power companion register file: one result item per event.
// Depends on nothing but the valid/ready handshake it carries.
interface pcrf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_level;
    logic [2:0] gpio_drive;

    modport source (output valid, output read_data, output irq_level, output gpio_drive,
                    input ready);
    modport sink   (input valid, input read_data, input irq_level, input gpio_drive,
                    output ready);
endinterface

/* hw/rtl/pcrf_ctrl_mem.sv */
// Control byte store: a 30-entry synchronous memory whose read data is registered.
// Per-entry valid bits make unwritten entries read as their reset value.
// Depends on pcrf_pkg for the command struct and the reset table.
module pcrf_ctrl_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  pcrf_pkg::mem_cmd_t cmd,
    output logic [7:0]        rd_data
);

    logic [7:0]                  mem [pcrf_pkg::NumCtrl];
    logic [pcrf_pkg::NumCtrl-1:0] valid_reg;
    logic [pcrf_pkg::NumCtrl-1:0] valid_next;
    logic [7:0]                  rd_raw_reg;
    logic                        rd_valid_reg;
    logic [7:0]                  rd_reset_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.slot] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_raw_reg   <= mem[cmd.slot];
            rd_valid_reg <= valid_reg[cmd.slot];
            rd_reset_reg <= pcrf_pkg::reset_value(cmd.slot);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clear)
        begin
            valid_next = '0;
        end
        else if (cmd.wr_en)
        begin
            valid_next[cmd.slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // An entry never written since reset or the last device-off reads as its default.
    assign rd_data = rd_valid_reg ? rd_raw_reg : rd_reset_reg;

    a_wr_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !cmd.rd_en && !cmd.clear)
        else $error("control store write overlaps a read or clear");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en || cmd.rd_en) |-> cmd.slot < 5'(pcrf_pkg::NumCtrl))
        else $error("control store access beyond its depth");

    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> valid_reg == '0)
        else $error("device-off did not drop every stored control byte");

endmodule

/* hw/rtl/power_companion_register_file.sv */
// Top level of the power companion register file: bus decode, pointer, interrupt
// and GPIO registers, with the control bytes held in pcrf_ctrl_mem.
// Depends on pcrf_pkg, pcrf_req_if, pcrf_rsp_if and pcrf_ctrl_mem.
//
//   Channel  Dir  Payload                          Handshake
//   req      in   op, data, pin, level             valid / ready
//   rsp      out  read_data, irq_level, gpio_drive valid / ready
//
// Each item takes two steps: the accept cycle decodes it, updates the registers
// and issues the control memory access; the finish step then collects the memory
// read data into the output register. A new item is taken once that is done, so
// the output register may still hold a result the sink has not yet taken.
// Reset is asynchronous and active low; the control bytes need no clearing pass.
// A stalled sink holds the finish step, and with it the request channel.
module power_companion_register_file (
    input  logic             clk,
    input  logic             rst_n,
    pcrf_req_if.sink         req,
    pcrf_rsp_if.source       rsp
);

    logic [7:0]  ptr_reg, ptr_next;
    logic        expect_reg, expect_next;
    logic [15:0] rtc_comp_reg, rtc_comp_next;
    logic [15:0] int_mask_reg, int_mask_next;
    logic [15:0] int_status_reg, int_status_next;
    logic [7:0]  gpio_dir_reg, gpio_dir_next;
    logic [2:0]  gpio_out_reg, gpio_out_next;
    logic [2:0]  gpio_in_reg, gpio_in_next;
    logic        button_reg, button_next;
    logic        busy_reg, busy_next;
    logic        out_valid_reg, out_valid_next;

    logic [7:0]  rd_scalar_reg, rd_scalar_next;
    logic        rd_mem_reg, rd_mem_next;
    logic        rd_osc_reg, rd_osc_next;
    logic [7:0]  read_data_reg;
    logic        irq_reg;
    logic [2:0]  gpio_drive_reg;

    logic                accept;
    logic                finish;
    pcrf_pkg::slot_map_t ptr_map;
    pcrf_pkg::mem_cmd_t  cmd;
    logic [7:0]          mem_rd_data;
    logic [7:0]          scalar_read;
    logic [7:0]          rd_final;

    assign accept  = req.valid && req.ready;
    assign finish  = busy_reg && (!out_valid_reg || rsp.ready);
    assign ptr_map = pcrf_pkg::slot_of(ptr_reg);

    pcrf_ctrl_mem u_ctrl_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        unique case (ptr_reg)
            pcrf_pkg::ADDR_REVISION:    scalar_read = pcrf_pkg::REVISION_ID;
            pcrf_pkg::ADDR_MASK_LO:     scalar_read = int_mask_reg[7:0];
            pcrf_pkg::ADDR_MASK_HI:     scalar_read = int_mask_reg[15:8];
            pcrf_pkg::ADDR_STATUS_LO:   scalar_read = int_status_reg[7:0];
            pcrf_pkg::ADDR_STATUS_HI:   scalar_read = int_status_reg[15:8];
            pcrf_pkg::ADDR_GPIO_DIR:    scalar_read = gpio_dir_reg;
            pcrf_pkg::ADDR_GPIO_IN:
                scalar_read = {5'b00000, gpio_in_reg | (gpio_out_reg & ~gpio_dir_reg[2:0])};
            pcrf_pkg::ADDR_GPIO_OUT:    scalar_read = {5'b00000, gpio_out_reg};
            pcrf_pkg::ADDR_RTC_COMP_HI: scalar_read = rtc_comp_reg[15:8];
            pcrf_pkg::ADDR_RTC_COMP_LO: scalar_read = rtc_comp_reg[7:0];
            default:                    scalar_read = 8'h00;
        endcase
    end

    always_comb
    begin
        ptr_next        = ptr_reg;
        expect_next     = expect_reg;
        rtc_comp_next   = rtc_comp_reg;
        int_mask_next   = int_mask_reg;
        int_status_next = int_status_reg;
        gpio_dir_next   = gpio_dir_reg;
        gpio_out_next   = gpio_out_reg;
        gpio_in_next    = gpio_in_reg;
        button_next     = button_reg;
        rd_scalar_next  = 8'h00;
        rd_mem_next     = 1'b0;
        rd_osc_next     = 1'b0;
        cmd             = '0;

        if (accept)
        begin
            unique case (req.op)
                pcrf_pkg::OP_START:
                begin
                    expect_next = 1'b1;
                end
                pcrf_pkg::OP_WRITE:
                begin
                    if (expect_reg)
                    begin
                        ptr_next    = req.data;
                        expect_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 8'd1;
                        if (ptr_map.hit)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.slot    = ptr_map.slot;
                            cmd.wr_data = pcrf_pkg::write_value(ptr_map.slot, req.data);
                        end
                        else
                        begin
                            unique case (ptr_reg)
                                pcrf_pkg::ADDR_DEVICE_OFF:
                                begin
                                    if (req.data[0])
                                    begin
                                        ptr_next        = 8'h00;
                                        rtc_comp_next   = 16'h0000;
                                        int_mask_next   = pcrf_pkg::INT_MASK_RESET;
                                        int_status_next = 16'h0000;
                                        gpio_dir_next   = pcrf_pkg::GPIO_DIR_RESET;
                                        gpio_out_next   = 3'b000;
                                        cmd.clear       = 1'b1;
                                    end
                                end
                                // The low mask byte keeps only bits 8 to 11 of the old mask.
                                pcrf_pkg::ADDR_MASK_LO:
                                    int_mask_next = {4'h0, int_mask_reg[11:8], req.data};
                                pcrf_pkg::ADDR_MASK_HI:
                                    int_mask_next = {req.data, int_mask_reg[7:0]};
                                pcrf_pkg::ADDR_ACK_LO:
                                    int_status_next = int_status_reg & ~{8'h00, req.data};
                                pcrf_pkg::ADDR_ACK_HI:
                                    int_status_next = int_status_reg & ~{req.data, 8'h00};
                                pcrf_pkg::ADDR_GPIO_DIR:
                                    gpio_dir_next = req.data & pcrf_pkg::GPIO_DIR_MASK;
                                pcrf_pkg::ADDR_GPIO_OUT:
                                    gpio_out_next = req.data[2:0];
                                pcrf_pkg::ADDR_RTC_COMP_HI:
                                    rtc_comp_next = {req.data, rtc_comp_reg[7:0]};
                                pcrf_pkg::ADDR_RTC_COMP_LO:
                                    rtc_comp_next = {rtc_comp_reg[15:8], req.data};
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
                pcrf_pkg::OP_READ:
                begin
                    ptr_next = ptr_reg + 8'd1;
                    if (ptr_map.hit)
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.slot    = ptr_map.slot;
                        rd_mem_next = 1'b1;
                        rd_osc_next = (ptr_map.slot == pcrf_pkg::SLOT_OSC);
                    end
                    else
                    begin
                        rd_scalar_next = scalar_read;
                    end
                end
                pcrf_pkg::OP_PIN:
                begin
                    if (req.pin != pcrf_pkg::PIN_BUTTON)
                    begin
                        gpio_in_next[req.pin] = req.level;
                    end
                    else
                    begin
                        if (!button_reg && req.level)
                        begin
                            int_status_next[pcrf_pkg::BUTTON_STATUS_BIT] = 1'b1;
                        end
                        button_next = req.level;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            busy_next = busy_reg;
        end

        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= 8'h00;
            expect_reg     <= 1'b0;
            rtc_comp_reg   <= 16'h0000;
            int_mask_reg   <= pcrf_pkg::INT_MASK_RESET;
            int_status_reg <= 16'h0000;
            gpio_dir_reg   <= pcrf_pkg::GPIO_DIR_RESET;
            gpio_out_reg   <= 3'b000;
            gpio_in_reg    <= 3'b000;
            button_reg     <= 1'b0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ptr_reg        <= ptr_next;
            expect_reg     <= expect_next;
            rtc_comp_reg   <= rtc_comp_next;
            int_mask_reg   <= int_mask_next;
            int_status_reg <= int_status_next;
            gpio_dir_reg   <= gpio_dir_next;
            gpio_out_reg   <= gpio_out_next;
            gpio_in_reg    <= gpio_in_next;
            button_reg     <= button_next;
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // The oscillator register always reads with its top bit set.
    assign rd_final = rd_mem_reg
                    ? (mem_rd_data | (rd_osc_reg ? pcrf_pkg::OSC_READ_SET : 8'h00))
                    : rd_scalar_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_scalar_reg <= rd_scalar_next;
            rd_mem_reg    <= rd_mem_next;
            rd_osc_reg    <= rd_osc_next;
        end
        if (finish)
        begin
            read_data_reg  <= rd_final;
            irq_reg        <= |(int_status_reg & ~int_mask_reg);
            gpio_drive_reg <= gpio_out_reg & ~gpio_dir_reg[2:0];
        end
    end

    assign req.ready      = !busy_reg;
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = read_data_reg;
    assign rsp.irq_level  = irq_reg;
    assign rsp.gpio_drive = gpio_drive_reg;

    a_mask_lo_clears_top: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.op == pcrf_pkg::OP_WRITE && !expect_reg
            && ptr_reg == pcrf_pkg::ADDR_MASK_LO
        |=> int_mask_reg[15:12] == 4'h0)
        else $error("low mask byte write left upper mask bits set");

    a_device_off: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.op == pcrf_pkg::OP_WRITE && !expect_reg
            && ptr_reg == pcrf_pkg::ADDR_DEVICE_OFF && req.data[0]
        |=> ptr_reg == 8'h00 && int_status_reg == 16'h0000
            && int_mask_reg == pcrf_pkg::INT_MASK_RESET)
        else $error("device-off did not restore the defaults");

    a_button_edge: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.op == pcrf_pkg::OP_PIN && req.pin == pcrf_pkg::PIN_BUTTON
            && req.level && !button_reg
        |=> int_status_reg[pcrf_pkg::BUTTON_STATUS_BIT])
        else $error("power button rising edge not flagged in status");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg))
        else $error("result presented without an item in progress");

endmodule
